[rtl/core/tbas_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tbas_pkg
// Shared constants, types and helpers for the tared block average unit.
// ============================================================================
package tbas_pkg;

    // Block and history geometry
    localparam int BLOCK_LENGTH  = 4000;
    localparam int HISTORY_DEPTH = 200;

    // Field widths
    localparam int VAL_W      = 13;
    localparam int SAMPLE_W   = 12;
    localparam int TOL_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Reset tolerance
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

    // Corrected sample is VAL_W+1 bits signed; reference +/- tolerance fits BAND_W
    localparam int CORR_W = VAL_W + 1;
    localparam int BAND_W = VAL_W + 2;

    // Block accumulator and reciprocal division by BLOCK_LENGTH
    localparam int CNT_W       = $clog2(BLOCK_LENGTH + 1);
    localparam int SUM_W       = CORR_W + $clog2(BLOCK_LENGTH);
    localparam int MAG_W       = SUM_W - 1;
    localparam int BLK_SHIFT   = MAG_W + $clog2(BLOCK_LENGTH);
    localparam int BLK_RECIP_W = MAG_W + 1;
    localparam int BLK_PROD_W  = MAG_W + BLK_RECIP_W;
    localparam logic [BLK_RECIP_W-1:0] BLK_RECIP = BLK_RECIP_W'(
        ((64'd1 << BLK_SHIFT) + 64'(BLOCK_LENGTH) - 64'd1) / 64'(BLOCK_LENGTH));
    localparam int QUO_W       = BAND_W - 1;

    // History ring and reciprocal division by HISTORY_DEPTH
    localparam int HIST_AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HSUM_W       = VAL_W + $clog2(HISTORY_DEPTH);
    localparam int HIST_SHIFT   = HSUM_W + $clog2(HISTORY_DEPTH);
    localparam int HIST_RECIP_W = HSUM_W + 1;
    localparam int HIST_PROD_W  = HSUM_W + HIST_RECIP_W;
    localparam logic [HIST_RECIP_W-1:0] HIST_RECIP = HIST_RECIP_W'(
        ((64'd1 << HIST_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam int HQUO_W       = VAL_W;
    localparam int OOB_W        = $clog2(HISTORY_DEPTH + 1);

    localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(4095);
    localparam logic signed [VAL_W-1:0] VAL_MIN = VAL_W'(-4096);

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARE_MODE = 2'd0,
        REG_REFERENCE = 2'd1,
        REG_TOLERANCE = 2'd2
    } t_reg_idx;

    // Ring read side: advance pointer or rewind it on clear
    typedef struct packed {
        logic en;
        logic clr;
    } t_ring_rd;

    // Ring update side
    typedef struct packed {
        logic               en;
        logic               clr;
        logic [HIST_AW-1:0] addr;
        t_val               data;
    } t_ring_wr;

    // Ring status after the update in flight
    typedef struct packed {
        logic signed [HSUM_W-1:0] hsum;
        logic                     uniform;
    } t_ring_stat;

    function automatic t_val sat_val(input logic signed [BAND_W-1:0] v);
        t_val r;
        if (v > BAND_W'(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (v < BAND_W'(VAL_MIN)) begin
            r = VAL_MIN;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/tbas_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tbas_in_if
// Request channel: command and raw converter sample.
// ============================================================================
interface tbas_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [tbas_pkg::SAMPLE_W-1:0]     sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

[rtl/core/tbas_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tbas_out_if
// Result channel: block average, history statistics and offset.
// ============================================================================
interface tbas_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tbas_pkg::VAL_W-1:0] block_average;
    logic signed [tbas_pkg::VAL_W-1:0] history_mean;
    logic                              uniform;
    logic signed [tbas_pkg::VAL_W-1:0] offset_now;
    logic                              was_tare;

    modport source (output valid, output block_average, output history_mean,
                    output uniform, output offset_now, output was_tare, input ready);
    modport sink   (input valid, input block_average, input history_mean,
                    input uniform, input offset_now, input was_tare, output ready);
endinterface

[rtl/core/tared_block_average_stability_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tared_block_average_stability_unit
// Tared boxcar decimating average with history ring and stability flag.
// ============================================================================
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  i_in     | in  | valid / ready        | cmd, sample
//  o_out    | out | valid / ready        | block_average, history_mean,
//           |     |                      | uniform, offset_now, was_tare
//  i_cfg_*  | in  | write enable only    | i_cfg_idx, i_cfg_data
//
//  One request per cycle while the first stage is free and no tare block holds
//  input. A result passes the accumulate, multiply, ring read, ring update,
//  mean multiply and output registers in turn. After the last sample of a block
//  in tare mode, input pauses until the offset that feeds the subtraction is
//  updated. Reset is synchronous; the ring is emptied at once by per-entry valid
//  bits, so there is no clearing pass. Output stalls fill the pipeline registers;
//  samples keep flowing while the first stage is free.
// ============================================================================
module tared_block_average_stability_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    tbas_in_if.sink                              i_in,
    tbas_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [tbas_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tbas_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration
    logic                                   r_tare_mode;
    tbas_pkg::t_val                         r_ref_level;
    logic [tbas_pkg::TOL_W-1:0]             r_tolerance;

    // Block accumulator and offset
    logic signed [tbas_pkg::SUM_W-1:0]      r_blk_sum;
    logic [tbas_pkg::CNT_W-1:0]             r_blk_cnt;
    tbas_pkg::t_val                         r_offset;

    // Pipeline stages
    logic                                   r_b_vld, r_b_clr, r_b_tare;
    logic signed [tbas_pkg::SUM_W-1:0]      r_b_sum;
    logic                                   r_c_vld, r_c_clr, r_c_tare, r_c_neg;
    logic [tbas_pkg::BLK_PROD_W-1:0]        r_c_prod;
    logic                                   r_d_vld, r_d_clr, r_d_tare;
    tbas_pkg::t_val                         r_d_avg;
    logic [tbas_pkg::HIST_AW-1:0]           r_d_addr;
    logic                                   r_e_vld, r_e_tare, r_e_uniform;
    tbas_pkg::t_val                         r_e_avg, r_e_offset;
    logic signed [tbas_pkg::HSUM_W-1:0]     r_e_hsum;
    logic                                   r_f_vld, r_f_tare, r_f_uniform, r_f_neg;
    tbas_pkg::t_val                         r_f_avg, r_f_offset;
    logic [tbas_pkg::HIST_PROD_W-1:0]       r_f_prod;
    logic                                   r_o_vld, r_o_tare, r_o_uniform;
    tbas_pkg::t_val                         r_o_avg, r_o_mean, r_o_offset;

    // Combinational
    logic                                   free_o, adv_f, free_f, adv_e, free_e;
    logic                                   adv_d, free_d, adv_c, free_c, adv_b, free_b;
    logic                                   tare_hold, in_ready, in_fire, is_clear;
    logic                                   blk_done, b_load;
    logic signed [tbas_pkg::CORR_W-1:0]     corr;
    logic signed [tbas_pkg::SUM_W-1:0]      n_blk_sum;
    logic [tbas_pkg::SUM_W-1:0]             b_abs;
    logic [tbas_pkg::QUO_W-1:0]             c_quo;
    logic signed [tbas_pkg::BAND_W-1:0]     c_quo_s, c_avg_w;
    tbas_pkg::t_val                         c_avg;
    tbas_pkg::t_val                         n_offset;
    logic signed [tbas_pkg::BAND_W-1:0]     d_off_sum;
    logic [tbas_pkg::HSUM_W-1:0]            e_abs;
    logic [tbas_pkg::HQUO_W-1:0]            f_quo;
    logic signed [tbas_pkg::BAND_W-1:0]     f_quo_s, f_mean_w;
    tbas_pkg::t_ring_rd                     ring_rd;
    tbas_pkg::t_ring_wr                     ring_wr;
    tbas_pkg::t_ring_stat                   ring_stat;
    logic [tbas_pkg::HIST_AW-1:0]           ring_addr;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare_mode <= 1'b0;
            r_ref_level <= '0;
            r_tolerance <= tbas_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (tbas_pkg::t_reg_idx'(i_cfg_idx))
                tbas_pkg::REG_TARE_MODE: r_tare_mode <= i_cfg_data[0];
                tbas_pkg::REG_REFERENCE: r_ref_level <= i_cfg_data[tbas_pkg::VAL_W-1:0];
                tbas_pkg::REG_TOLERANCE: r_tolerance <= i_cfg_data[tbas_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    assign free_o = !r_o_vld || o_out.ready;
    assign adv_f  = r_f_vld && free_o;
    assign free_f = !r_f_vld || adv_f;
    assign adv_e  = r_e_vld && free_f;
    assign free_e = !r_e_vld || adv_e;
    // a clear retires in the update stage and needs no room downstream
    assign adv_d  = r_d_vld && (r_d_clr || free_e);
    assign free_d = !r_d_vld || adv_d;
    assign adv_c  = r_c_vld && free_d;
    assign free_c = !r_c_vld || adv_c;
    assign adv_b  = r_b_vld && free_c;
    assign free_b = !r_b_vld || adv_b;

    // hold input until a tare block has updated the offset
    assign tare_hold = (r_b_vld && r_b_tare) || (r_c_vld && r_c_tare) ||
                       (r_d_vld && r_d_tare);
    assign in_ready  = free_b && !tare_hold;
    assign in_fire   = i_in.valid && in_ready;
    assign is_clear  = (tbas_pkg::t_cmd'(i_in.cmd) == tbas_pkg::CMD_CLEAR);

    assign i_in.ready = in_ready;

    // ------------------------------------------------------------------
    // Stage A: offset correction and block accumulation
    // ------------------------------------------------------------------
    assign corr      = $signed({2'b00, i_in.sample}) - tbas_pkg::CORR_W'(r_offset);
    assign n_blk_sum = r_blk_sum + tbas_pkg::SUM_W'(corr);
    assign blk_done  = (r_blk_cnt == tbas_pkg::CNT_W'(tbas_pkg::BLOCK_LENGTH - 1));
    assign b_load    = in_fire && (is_clear || blk_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_sum <= '0;
            r_blk_cnt <= '0;
        end else if (in_fire) begin
            if (is_clear || blk_done) begin
                r_blk_sum <= '0;
                r_blk_cnt <= '0;
            end else begin
                r_blk_sum <= n_blk_sum;
                r_blk_cnt <= r_blk_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_load) begin
            r_b_vld <= 1'b1;
        end else if (adv_b) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_clr  <= is_clear;
            r_b_tare <= !is_clear && r_tare_mode;
            r_b_sum  <= n_blk_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: magnitude times reciprocal of the block length
    // ------------------------------------------------------------------
    assign b_abs = r_b_sum[tbas_pkg::SUM_W-1] ? tbas_pkg::SUM_W'(-r_b_sum)
                                              : tbas_pkg::SUM_W'(r_b_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv_b) begin
            r_c_vld <= 1'b1;
        end else if (adv_c) begin
            r_c_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_c_clr  <= r_b_clr;
            r_c_tare <= r_b_tare;
            r_c_neg  <= r_b_sum[tbas_pkg::SUM_W-1];
            r_c_prod <= b_abs[tbas_pkg::MAG_W-1:0] * tbas_pkg::BLK_RECIP;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: quotient, sign, saturation; issue ring read
    // ------------------------------------------------------------------
    assign c_quo   = r_c_prod[tbas_pkg::BLK_SHIFT +: tbas_pkg::QUO_W];
    assign c_quo_s = $signed(tbas_pkg::BAND_W'(c_quo));
    assign c_avg_w = r_c_neg ? -c_quo_s : c_quo_s;
    assign c_avg   = tbas_pkg::sat_val(c_avg_w);

    always_comb begin
        ring_rd.en  = adv_c && !r_c_clr && !r_c_tare;
        ring_rd.clr = adv_c && r_c_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (adv_c) begin
            r_d_vld <= 1'b1;
        end else if (adv_d) begin
            r_d_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_d_clr  <= r_c_clr;
            r_d_tare <= r_c_tare;
            r_d_avg  <= c_avg;
            r_d_addr <= ring_addr;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: ring update or offset update
    // ------------------------------------------------------------------
    always_comb begin
        ring_wr.en   = adv_d && !r_d_clr && !r_d_tare;
        ring_wr.clr  = adv_d && r_d_clr;
        ring_wr.addr = r_d_addr;
        ring_wr.data = r_d_avg;
    end

    tbas_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (ring_rd),
        .i_wr        (ring_wr),
        .i_ref_level (r_ref_level),
        .i_tolerance (r_tolerance),
        .o_rd_addr   (ring_addr),
        .o_stat      (ring_stat)
    );

    assign d_off_sum = tbas_pkg::BAND_W'(r_offset) + tbas_pkg::BAND_W'(r_d_avg);
    assign n_offset  = r_d_tare ? tbas_pkg::sat_val(d_off_sum) : r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (adv_d && r_d_tare) begin
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv_d && !r_d_clr) begin
            r_e_vld <= 1'b1;
        end else if (adv_e) begin
            r_e_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_d && !r_d_clr) begin
            r_e_tare    <= r_d_tare;
            r_e_avg     <= r_d_avg;
            r_e_offset  <= n_offset;
            r_e_hsum    <= ring_stat.hsum;
            r_e_uniform <= ring_stat.uniform;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: ring sum magnitude times reciprocal of the depth
    // ------------------------------------------------------------------
    assign e_abs = r_e_hsum[tbas_pkg::HSUM_W-1] ? tbas_pkg::HSUM_W'(-r_e_hsum)
                                                : tbas_pkg::HSUM_W'(r_e_hsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv_e) begin
            r_f_vld <= 1'b1;
        end else if (adv_f) begin
            r_f_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_e) begin
            r_f_tare    <= r_e_tare;
            r_f_avg     <= r_e_avg;
            r_f_offset  <= r_e_offset;
            r_f_uniform <= r_e_uniform;
            r_f_neg     <= r_e_hsum[tbas_pkg::HSUM_W-1];
            r_f_prod    <= e_abs * tbas_pkg::HIST_RECIP;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: history mean, output register
    // ------------------------------------------------------------------
    assign f_quo    = r_f_prod[tbas_pkg::HIST_SHIFT +: tbas_pkg::HQUO_W];
    assign f_quo_s  = $signed(tbas_pkg::BAND_W'(f_quo));
    assign f_mean_w = r_f_neg ? -f_quo_s : f_quo_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv_f) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_f) begin
            r_o_avg     <= r_f_avg;
            r_o_mean    <= tbas_pkg::sat_val(f_mean_w);
            r_o_uniform <= r_f_uniform;
            r_o_offset  <= r_f_offset;
            r_o_tare    <= r_f_tare;
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.block_average = r_o_avg;
    assign o_out.history_mean  = r_o_mean;
    assign o_out.uniform       = r_o_uniform;
    assign o_out.offset_now    = r_o_offset;
    assign o_out.was_tare      = r_o_tare;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_cnt < tbas_pkg::CNT_W'(tbas_pkg::BLOCK_LENGTH))
        else $error("block sample count out of range");

    a_single_tare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_b_vld && r_b_tare, r_c_vld && r_c_tare, r_d_vld && r_d_tare}) <= 1)
        else $error("more than one tare block in flight");

    a_tare_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_c_tare) |-> !r_b_vld)
        else $error("item entered behind a tare block");

    a_offset_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_offset != $past(r_offset)) |-> $past(adv_d && r_d_tare))
        else $error("offset changed without a tare block");

endmodule

[rtl/core/tbas_ring.sv]
`timescale 1ns / 1ps
// ============================================================================
// tbas_ring
// History ring in a synchronous RAM with per-entry valid bits, running sum
// and out-of-band count kept incrementally.
// ============================================================================
module tbas_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tbas_pkg::t_ring_rd              i_rd,
    input  tbas_pkg::t_ring_wr              i_wr,
    input  tbas_pkg::t_val                  i_ref_level,
    input  logic [tbas_pkg::TOL_W-1:0]      i_tolerance,
    output logic [tbas_pkg::HIST_AW-1:0]    o_rd_addr,
    output tbas_pkg::t_ring_stat            o_stat
);

    tbas_pkg::t_val                           mem [tbas_pkg::HISTORY_DEPTH];
    tbas_pkg::t_val                           r_q;
    logic [tbas_pkg::HISTORY_DEPTH-1:0]       r_valid;
    logic [tbas_pkg::HIST_AW-1:0]             r_rd_ptr;
    logic                                     r_old_vld;
    logic                                     r_fwd;
    tbas_pkg::t_val                           r_fwd_data;
    logic signed [tbas_pkg::HSUM_W-1:0]       r_hsum;
    logic [tbas_pkg::OOB_W-1:0]               r_oob_cnt;
    logic signed [tbas_pkg::BAND_W-1:0]       r_band_hi;
    logic signed [tbas_pkg::BAND_W-1:0]       r_band_lo;

    tbas_pkg::t_val                           old_val;
    logic                                     old_oob;
    logic                                     new_oob;
    logic signed [tbas_pkg::BAND_W-1:0]       new_hi;
    logic signed [tbas_pkg::BAND_W-1:0]       new_lo;
    logic                                     zero_oob;
    logic signed [tbas_pkg::HSUM_W-1:0]       n_hsum;
    logic [tbas_pkg::OOB_W-1:0]               n_oob_cnt;

    assign o_rd_addr = r_rd_ptr;

    // Entry being replaced: forwarded write, stored entry, or zero if never written
    always_comb begin
        if (r_fwd) begin
            old_val = r_fwd_data;
        end else if (r_old_vld) begin
            old_val = r_q;
        end else begin
            old_val = '0;
        end
    end

    assign old_oob = (tbas_pkg::BAND_W'(old_val) > r_band_hi) ||
                     (tbas_pkg::BAND_W'(old_val) < r_band_lo);
    assign new_oob = (tbas_pkg::BAND_W'(i_wr.data) > r_band_hi) ||
                     (tbas_pkg::BAND_W'(i_wr.data) < r_band_lo);

    assign new_hi   = tbas_pkg::BAND_W'(i_ref_level) +
                      $signed(tbas_pkg::BAND_W'(i_tolerance));
    assign new_lo   = tbas_pkg::BAND_W'(i_ref_level) -
                      $signed(tbas_pkg::BAND_W'(i_tolerance));
    assign zero_oob = (new_hi < 0) || (new_lo > 0);

    assign n_hsum    = r_hsum + tbas_pkg::HSUM_W'(i_wr.data)
                              - tbas_pkg::HSUM_W'(old_val);
    assign n_oob_cnt = r_oob_cnt - tbas_pkg::OOB_W'(old_oob) + tbas_pkg::OOB_W'(new_oob);

    always_comb begin
        o_stat.hsum    = i_wr.en ? n_hsum : r_hsum;
        o_stat.uniform = i_wr.en ? (n_oob_cnt == '0) : (r_oob_cnt == '0);
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q <= mem[r_rd_ptr];
        end
    end

    // Read-side hazard capture, held while the update stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_vld  <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (i_rd.en) begin
            r_old_vld  <= r_valid[r_rd_ptr] && !i_wr.clr;
            r_fwd      <= i_wr.en && (i_wr.addr == r_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
        end else if (i_rd.clr) begin
            r_rd_ptr <= '0;
        end else if (i_rd.en) begin
            if (r_rd_ptr == tbas_pkg::HIST_AW'(tbas_pkg::HISTORY_DEPTH - 1)) begin
                r_rd_ptr <= '0;
            end else begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_hsum    <= '0;
            r_oob_cnt <= '0;
            r_band_hi <= tbas_pkg::BAND_W'(tbas_pkg::TOL_RESET);
            r_band_lo <= -$signed(tbas_pkg::BAND_W'(tbas_pkg::TOL_RESET));
        end else if (i_wr.clr) begin
            r_valid   <= '0;
            r_hsum    <= '0;
            r_oob_cnt <= zero_oob ? tbas_pkg::OOB_W'(tbas_pkg::HISTORY_DEPTH) : '0;
            r_band_hi <= new_hi;
            r_band_lo <= new_lo;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_hsum             <= n_hsum;
            r_oob_cnt          <= n_oob_cnt;
        end
    end

    a_oob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oob_cnt <= tbas_pkg::OOB_W'(tbas_pkg::HISTORY_DEPTH))
        else $error("out-of-band count above ring depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ptr <= tbas_pkg::HIST_AW'(tbas_pkg::HISTORY_DEPTH - 1))
        else $error("ring pointer out of range");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.clr |=> (r_hsum == '0) && (r_valid == '0))
        else $error("ring not emptied by clear");

endmodule

[sim/tb_tared_block_average_stability_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_tared_block_average_stability_unit
// Self-checking bench for the tared block average unit. A table of whole
// blocks and register writes comes first, then random segments of blocks with
// clears, broken blocks and register changes, under sender and receiver idling
// and one long output stall. Block summaries are scored against typed row values
// or a cycle-free model of the averaging, tare, history ring and stability flag.
// ============================================================================
module tb_tared_block_average_stability_unit;
    import tbas_pkg::*;

    localparam int CLK_PERIOD         = 10;
    localparam int RESET_CYCLES       = 9;
    localparam int SETTLE_CYCLES      = 12;
    localparam int STALL_LIMIT        = 120000;
    localparam int HOLD_CYCLES        = 36000;
    localparam int NUM_SEGMENTS       = 9;
    localparam int FIRST_SEG_B        = 4;
    localparam int FIRST_SEG_C        = 5;
    localparam int BLOCKS_PER_SEGMENT = 4;
    localparam int PRESSURE_BLOCKS    = 9;
    localparam int NUM_DIR_ROWS       = 27;
    localparam int SAMPLE_MAX         = (1 << SAMPLE_W) - 1;

    typedef struct packed {
        t_val block_average;
        t_val history_mean;
        logic uniform;
        t_val offset_now;
        logic was_tare;
    } t_summary;

    typedef enum int {
        ROW_REQUEST,
        ROW_WRITE
    } t_row_kind;

    // A request row repeats one request; a typed expectation applies to its last request.
    typedef struct packed {
        t_row_kind kind;
        t_cmd      cmd;
        int        sample;
        int        count;
        t_reg_idx  reg_idx;
        int        reg_value;
        bit        typed;
        int        want_avg;
        int        want_mean;
        bit        want_uni;
        int        want_off;
        bit        want_tare;
    } t_dir_row;

    localparam t_dir_row DIRECTED_ROWS [NUM_DIR_ROWS] = '{
        // clear straight out of reset
        '{ROW_REQUEST, CMD_CLEAR,  4095, 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 0, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b1, 0, 0, 1'b1, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 4095, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b1, 4095, 20, 1'b0, 0, 1'b0},
        // partial block thrown away by a clear
        '{ROW_REQUEST, CMD_SAMPLE, 1234, 1000, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_CLEAR,  4095, 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 5, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b1, 5, 0, 1'b1, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TARE_MODE, 1,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        // tare block: offset takes the full-scale average, ring untouched
        '{ROW_REQUEST, CMD_SAMPLE, 4095, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b1, 4095, 0, 1'b1, 4095, 1'b1},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        // block sum of -1 truncates to zero, not to -1
        '{ROW_REQUEST, CMD_SAMPLE, 4095, BLOCK_LENGTH - 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 4094, 1, REG_TARE_MODE, 0,
          1'b1, 0, 0, 1'b1, 4095, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 0, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TARE_MODE, 1,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 0, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_REFERENCE, 4095,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TOLERANCE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        // new reference not yet in force
        '{ROW_REQUEST, CMD_SAMPLE, 100, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_CLEAR,  4095, 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 4095, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_REFERENCE, -4096,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_TOLERANCE, 4095,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_CLEAR,  4095, 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 0, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_WRITE,   CMD_SAMPLE, 0, 0, REG_REFERENCE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_CLEAR,  4095, 1, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0},
        '{ROW_REQUEST, CMD_SAMPLE, 2048, BLOCK_LENGTH, REG_TARE_MODE, 0,
          1'b0, 0, 0, 1'b0, 0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tbas_in_if  in_ch ();
    tbas_out_if out_ch ();

    tared_block_average_stability_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 10 ns period
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Model state
    bit      cfg_tare;
    int      cfg_reference;
    int      cfg_tolerance;
    int      live_reference;
    int      live_tolerance;
    int      tare_offset;
    longint  block_acc;
    int      block_fill;
    int      ring_val [HISTORY_DEPTH];
    int      ring_wp;
    int      ring_sum;
    int      ring_oob;

    t_summary pending_summaries [$];

    int src_idle_pct = 6;
    int snk_idle_pct = 80;
    bit hold_armed   = 1'b0;

    int error_count       = 0;
    int requests_taken    = 0;
    int clears_taken      = 0;
    int summaries_checked = 0;
    int tare_summaries    = 0;
    int uniform_summaries = 0;

    task automatic note_failure(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int clamp_val(input longint v);
        int r;
        if (v > longint'(VAL_MAX)) begin
            r = int'(VAL_MAX);
        end else if (v < longint'(VAL_MIN)) begin
            r = int'(VAL_MIN);
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

    function automatic int clamp_sample(input int v);
        return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
    endfunction

    function automatic bit beyond_band(input int v);
        return (v > live_reference + live_tolerance) ||
               (v < live_reference - live_tolerance);
    endfunction

    task automatic clear_ring();
        foreach (ring_val[k]) ring_val[k] = 0;
        ring_wp        = 0;
        ring_sum       = 0;
        live_reference = cfg_reference;
        live_tolerance = cfg_tolerance;
        ring_oob       = beyond_band(0) ? HISTORY_DEPTH : 0;
        block_acc      = 0;
        block_fill     = 0;
    endtask

    // Advance the model by one request; report the summary a completed block yields.
    task automatic apply_request(input t_cmd c, input logic [SAMPLE_W-1:0] s,
                                 output bit produced, output t_summary r);
        int avg;
        int old;
        produced = 1'b0;
        r        = '0;
        if (c == CMD_CLEAR) begin
            clear_ring();
            return;
        end
        block_acc += longint'(s) - tare_offset;
        block_fill++;
        if (block_fill < BLOCK_LENGTH) return;
        avg        = clamp_val(block_acc / BLOCK_LENGTH);
        block_acc  = 0;
        block_fill = 0;
        if (cfg_tare) begin
            tare_offset = clamp_val(longint'(tare_offset) + avg);
        end else begin
            old = ring_val[ring_wp];
            if (beyond_band(old)) ring_oob--;
            if (beyond_band(avg)) ring_oob++;
            ring_sum += avg - old;
            ring_val[ring_wp] = avg;
            ring_wp = (ring_wp + 1 >= HISTORY_DEPTH) ? 0 : ring_wp + 1;
        end
        r.block_average = VAL_W'(avg);
        r.history_mean  = VAL_W'(ring_sum / HISTORY_DEPTH);
        r.uniform       = (ring_oob == 0);
        r.offset_now    = VAL_W'(tare_offset);
        r.was_tare      = cfg_tare;
        produced        = 1'b1;
    endtask

    // Offer one request, hold it until taken, then queue what it yields.
    task automatic push_request(input t_cmd c, input logic [SAMPLE_W-1:0] s,
                                input bit typed, input t_summary want);
        bit       produced;
        t_summary r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= c;
        in_ch.sample <= s;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        requests_taken++;
        if (c == CMD_CLEAR) clears_taken++;
        apply_request(c, s, produced, r);
        if (produced) pending_summaries.push_back(typed ? want : r);
    endtask

    // Drop valid, let every summary drain, then give the pipeline time to go idle.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        t_val ref_bits;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_TARE_MODE: begin
                cfg_tare = value[0];
            end
            REG_REFERENCE: begin
                ref_bits      = value[VAL_W-1:0];
                cfg_reference = ref_bits;
            end
            REG_TOLERANCE: begin
                cfg_tolerance = int'(value[TOL_W-1:0]);
            end
            default: begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: score summaries, idle at random, hold off once for a long stretch.
    initial begin
        t_summary got;
        t_summary want;
        int       hold_left;
        bit       hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.block_average = out_ch.block_average;
                got.history_mean  = out_ch.history_mean;
                got.uniform       = out_ch.uniform;
                got.offset_now    = out_ch.offset_now;
                got.was_tare      = out_ch.was_tare;
                summaries_checked++;
                if (got.was_tare === 1'b1) tare_summaries++;
                if (got.uniform === 1'b1) uniform_summaries++;
                if (pending_summaries.size() == 0) begin
                    note_failure($sformatf("summary %0d arrived with nothing expected",
                                           summaries_checked));
                end else begin
                    want = pending_summaries.pop_front();
                    if (got.block_average !== want.block_average)
                        note_failure($sformatf("summary %0d block_average %0d, expected %0d",
                            summaries_checked, got.block_average, want.block_average));
                    if (got.history_mean !== want.history_mean)
                        note_failure($sformatf("summary %0d history_mean %0d, expected %0d",
                            summaries_checked, got.history_mean, want.history_mean));
                    if (got.uniform !== want.uniform)
                        note_failure($sformatf("summary %0d uniform %0b, expected %0b",
                            summaries_checked, got.uniform, want.uniform));
                    if (got.offset_now !== want.offset_now)
                        note_failure($sformatf("summary %0d offset_now %0d, expected %0d",
                            summaries_checked, got.offset_now, want.offset_now));
                    if (got.was_tare !== want.was_tare)
                        note_failure($sformatf("summary %0d was_tare %0b, expected %0b",
                            summaries_checked, got.was_tare, want.was_tare));
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog: end the run after too long without any accepted transfer.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ERROR @%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_tared_block_average_stability_unit: FAIL");
        $finish;
    end

    initial begin
        t_dir_row row;
        t_summary want;
        int       ref_pick;
        int       tol_pick;
        int       mode;
        int       base;
        int       spread;
        int       value;
        int       n;
        int       num_blocks;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_TARE_MODE;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_SAMPLE;
        in_ch.sample <= '0;
        cfg_tare      = 1'b0;
        cfg_reference = 0;
        cfg_tolerance = int'(TOL_RESET);
        tare_offset   = 0;
        clear_ring();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                wait_quiet();
                write_reg(row.reg_idx, row.reg_value);
            end else begin
                want.block_average = VAL_W'(row.want_avg);
                want.history_mean  = VAL_W'(row.want_mean);
                want.uniform       = row.want_uni;
                want.offset_now    = VAL_W'(row.want_off);
                want.was_tare      = row.want_tare;
                for (int k = 0; k < row.count; k++) begin
                    push_request(row.cmd, SAMPLE_W'(row.sample),
                                 row.typed && (k == row.count - 1), want);
                end
            end
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            wait_quiet();
            if (seg == FIRST_SEG_B) begin
                src_idle_pct = 80;
                snk_idle_pct = 6;
            end else if (seg == FIRST_SEG_C) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case ($urandom_range(0, 4))
                0:       ref_pick = int'(VAL_MIN);
                1:       ref_pick = int'(VAL_MAX);
                2:       ref_pick = 0;
                3:       ref_pick = int'($urandom_range(0, 128)) - 64;
                default: ref_pick = int'($urandom_range(0, 8191)) - 4096;
            endcase
            case ($urandom_range(0, 4))
                0:       tol_pick = 0;
                1:       tol_pick = SAMPLE_MAX;
                2:       tol_pick = int'(TOL_RESET);
                3:       tol_pick = int'($urandom_range(0, 127));
                default: tol_pick = int'($urandom_range(0, SAMPLE_MAX));
            endcase
            write_reg(REG_TARE_MODE, (seg % 3 == 1) ? 1 : 0);
            write_reg(REG_REFERENCE, ref_pick);
            write_reg(REG_TOLERANCE, tol_pick);
            // latch the new band
            push_request(CMD_CLEAR, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);

            // under the long output hold, send more blocks than the pipeline can hold
            num_blocks = (seg == FIRST_SEG_C) ? PRESSURE_BLOCKS : BLOCKS_PER_SEGMENT;
            for (int blk = 0; blk < num_blocks; blk++) begin
                // now and then abandon a block halfway with a clear
                if ($urandom_range(0, 5) == 0) begin
                    n = $urandom_range(1, BLOCK_LENGTH - 1);
                    repeat (n) begin
                        push_request(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                                     1'b0, '0);
                    end
                    push_request(CMD_CLEAR, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                                 1'b0, '0);
                end
                if (seg == FIRST_SEG_C && blk == 0) hold_armed = 1'b1;
                mode   = $urandom_range(0, 3);
                base   = $urandom_range(0, SAMPLE_MAX);
                spread = $urandom_range(0, 255);
                if (mode == 3) begin
                    // track the offset so corrected averages sit near zero
                    base = clamp_sample(tare_offset + int'($urandom_range(0, 40)) - 20);
                end
                for (int k = 0; k < BLOCK_LENGTH; k++) begin
                    case (mode)
                        0: begin
                            value = $urandom_range(0, SAMPLE_MAX);
                        end
                        1: begin
                            value = clamp_sample(base + int'($urandom_range(0, 2 * spread))
                                                 - spread);
                        end
                        2: begin
                            case (base % 3)
                                0:       value = 0;
                                1:       value = SAMPLE_MAX;
                                default: value = (k % 2 == 0) ? SAMPLE_MAX : 0;
                            endcase
                        end
                        default: begin
                            value = clamp_sample(base + int'($urandom_range(0, 16)) - 8);
                        end
                    endcase
                    push_request(CMD_SAMPLE, SAMPLE_W'(value), 1'b0, '0);
                end
            end
        end

        wait_quiet();
        if (pending_summaries.size() != 0) begin
            note_failure($sformatf("%0d summaries never arrived", pending_summaries.size()));
        end
        $display("Run covered %0d requests (%0d clears): a directed table and %0d random segments",
                 requests_taken, clears_taken, NUM_SEGMENTS);
        $display("Scored %0d block summaries: %0d tare updates, %0d with a uniform ring",
                 summaries_checked, tare_summaries, uniform_summaries);
        if (error_count == 0) begin
            $display("tb_tared_block_average_stability_unit: PASS");
        end else begin
            $display("tb_tared_block_average_stability_unit: FAIL");
        end
        $finish;
    end

endmodule
